/* design/msr_pkg.sv */
// Shared types, constants and helper functions for the masked stream reduction block.
`timescale 1ns / 1ps

package msr_pkg;

  // Field and bus widths
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned MASK_W      = 32;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned OUT_POS_W   = 17;
  localparam int unsigned OUT_CNT_W   = 17;
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_FIELD_W = ACC_W + OUT_POS_W + OUT_CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam int unsigned DEFAULT_MAX_SAMPLES = 65536;

  // Register reset values
  localparam logic [MODE_W-1:0] RESET_MODE   = 4'd0;
  localparam logic [MASK_W-1:0] RESET_MASK   = 32'd1;
  localparam logic              RESET_FILTER = 1'b1;

  // Extreme accumulator values
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM    = 4'd0,
    MODE_SUMSQ  = 4'd1,
    MODE_SUMABS = 4'd2,
    MODE_MIN    = 4'd3,
    MODE_MAX    = 4'd4,
    MODE_AVE    = 4'd5,
    MODE_AVESQ  = 4'd6,
    MODE_AVEABS = 4'd7,
    MODE_MAXABS = 4'd8,
    MODE_MINABS = 4'd9
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REDUCE_MODE     = 2'd0,
    REG_GROUP_MASK      = 2'd1,
    REG_FILTER_BY_GROUP = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_FIN,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
    logic need_div;
    logic div_done;
    logic out_full;
  } status_t;

  // Unused mode codes behave as sum
  function automatic mode_e eff_mode(input logic [MODE_W-1:0] m);
    mode_e r;
    if (m > MODE_MINABS) begin
      r = MODE_SUM;
    end else begin
      r = mode_e'(m);
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] start_value(input mode_e m);
    logic signed [ACC_W-1:0] r;
    unique case (m)
      MODE_MIN, MODE_MINABS: r = ACC_MAX;
      MODE_MAX:              r = ACC_MIN;
      default:               r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_avg(input mode_e m);
    return (m == MODE_AVE) || (m == MODE_AVESQ) || (m == MODE_AVEABS);
  endfunction

  function automatic logic is_minmax(input mode_e m);
    return (m == MODE_MIN) || (m == MODE_MAX) || (m == MODE_MAXABS) || (m == MODE_MINABS);
  endfunction

endpackage

/* design/msr_ctrl.sv */
// Controller state machine sequencing capture, accumulate, divide and emit.
`timescale 1ns / 1ps

module msr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  msr_pkg::status_t status_i,
  output logic             in_ready_o,
  output msr_pkg::cmd_t    cmd_o
);

  msr_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = msr_pkg::ST_ACC;
      end
      msr_pkg::ST_ACC: begin
        state_d = status_i.last ? msr_pkg::ST_FIN : msr_pkg::ST_IDLE;
      end
      msr_pkg::ST_FIN: begin
        state_d = status_i.need_div ? msr_pkg::ST_DIV : msr_pkg::ST_EMIT;
      end
      msr_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = msr_pkg::ST_EMIT;
      end
      msr_pkg::ST_EMIT: begin
        if (!status_i.out_full) state_d = msr_pkg::ST_IDLE;
      end
      default: state_d = msr_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = (state_q == msr_pkg::ST_IDLE);
    cmd_o.capture     = (state_q == msr_pkg::ST_IDLE) && in_valid_i;
    cmd_o.update      = (state_q == msr_pkg::ST_ACC);
    cmd_o.div_start   = (state_q == msr_pkg::ST_FIN) && status_i.need_div;
    cmd_o.load_out    = (state_q == msr_pkg::ST_EMIT) && !status_i.out_full;
  end

endmodule

/* design/msr_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
`timescale 1ns / 1ps

module msr_div #(
  parameter int unsigned DVS_W = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [msr_pkg::ACC_W-1:0]  dividend_i,
  input  logic        [DVS_W-1:0]           divisor_i,
  output logic                              done_o,
  output logic signed [msr_pkg::ACC_W-1:0]  quotient_o
);

  localparam int unsigned CNT_W = $clog2(msr_pkg::ACC_W);

  logic [msr_pkg::ACC_W-1:0] quot_q, quot_d;
  logic [DVS_W-1:0]          rem_q, rem_d;
  logic [DVS_W-1:0]          dvs_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q, neg_q;
  logic [DVS_W:0]            rem_sh;
  logic [DVS_W:0]            rem_diff;
  logic                      fits;

  // One restoring step
  always_comb begin
    rem_sh   = {rem_q, quot_q[msr_pkg::ACC_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_q};
    fits     = (rem_sh >= {1'b0, dvs_q});
    rem_d    = fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    quot_d   = {quot_q[msr_pkg::ACC_W-2:0], fits};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(msr_pkg::ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i[msr_pkg::ACC_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      neg_q  <= dividend_i[msr_pkg::ACC_W-1];
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(~quot_q + 1'b1) : $signed(quot_q);

endmodule

/* design/msr_datapath.sv */
// Datapath: config registers, sample capture, saturating accumulator, winner tracking, output register.
`timescale 1ns / 1ps

module msr_datapath #(
  parameter int unsigned MAX_SAMPLES = msr_pkg::DEFAULT_MAX_SAMPLES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [msr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [msr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [msr_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic                                in_last_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [msr_pkg::OUT_TDATA_W-1:0]     out_data_o,
  input  msr_pkg::cmd_t                       cmd_i,
  output msr_pkg::status_t                    status_o
);

  localparam int unsigned PW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = msr_pkg::ACC_W;
  localparam int unsigned SW = msr_pkg::SAMPLE_W;

  // Configuration registers
  logic [msr_pkg::MODE_W-1:0] mode_q;
  logic [msr_pkg::MASK_W-1:0] mask_q;
  logic                       filter_q;
  msr_pkg::mode_e             mode;

  // Captured sample
  logic signed [SW-1:0]  samp_q;
  logic        [SW-1:0]  mag_q;
  logic        [AW-1:0]  sq_q;
  logic                  incl_q;
  logic                  last_q;
  logic signed [SW-1:0]  in_samp;
  logic        [SW-1:0]  in_mag;

  // Run state
  logic signed [AW-1:0]  acc_q, acc_d;
  logic        [PW-1:0]  pos_q, pos_d;
  logic        [CW-1:0]  cnt_q, cnt_d;
  logic        [PW-1:0]  best_q, best_d;
  logic                  best_vld_q, best_vld_d;

  // Update terms
  logic signed [AW-1:0]  v_ext, mag_ext, addend, sat_sum, cand;
  logic signed [AW:0]    sum_wide;
  logic                  better;

  // Output register
  logic                              out_valid_q;
  logic signed [AW-1:0]              res_q;
  logic [msr_pkg::OUT_POS_W-1:0]     win_q;
  logic [msr_pkg::OUT_CNT_W-1:0]     tot_q;

  logic                  need_div;
  logic                  div_done;
  logic signed [AW-1:0]  div_quot;

  assign mode = msr_pkg::eff_mode(mode_q);

  // Config writes; unknown index is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= msr_pkg::RESET_MODE;
      mask_q   <= msr_pkg::RESET_MASK;
      filter_q <= msr_pkg::RESET_FILTER;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        msr_pkg::REG_REDUCE_MODE:     mode_q   <= cfg_wdata_i[msr_pkg::MODE_W-1:0];
        msr_pkg::REG_GROUP_MASK:      mask_q   <= cfg_wdata_i[msr_pkg::MASK_W-1:0];
        msr_pkg::REG_FILTER_BY_GROUP: filter_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Capture: magnitude and registered square of the incoming sample
  assign in_samp = $signed(in_data_i[SW-1:0]);
  assign in_mag  = in_samp[SW-1] ? (~in_data_i[SW-1:0] + 1'b1) : in_data_i[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      samp_q <= in_samp;
      mag_q  <= in_mag;
      sq_q   <= in_mag * in_mag;
      incl_q <= !filter_q || ((in_data_i[SW +: msr_pkg::MASK_W] & mask_q) != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.capture) begin
      last_q <= in_last_i;
    end
  end

  // Addend and saturating add
  always_comb begin
    v_ext   = {{(AW-SW){samp_q[SW-1]}}, samp_q};
    mag_ext = {{(AW-SW){1'b0}}, mag_q};
    unique case (mode)
      msr_pkg::MODE_SUMSQ, msr_pkg::MODE_AVESQ:   addend = {16'd0, sq_q[AW-1:16]};
      msr_pkg::MODE_SUMABS, msr_pkg::MODE_AVEABS: addend = mag_ext;
      default:                                    addend = v_ext;
    endcase
    sum_wide = {acc_q[AW-1], acc_q} + {addend[AW-1], addend};
    if (sum_wide[AW] != sum_wide[AW-1]) begin
      sat_sum = sum_wide[AW] ? msr_pkg::ACC_MIN : msr_pkg::ACC_MAX;
    end else begin
      sat_sum = sum_wide[AW-1:0];
    end
  end

  // Compare for the extreme modes; only strictly better samples win
  always_comb begin
    unique case (mode)
      msr_pkg::MODE_MIN: begin
        cand   = v_ext;
        better = (v_ext < acc_q);
      end
      msr_pkg::MODE_MAX: begin
        cand   = v_ext;
        better = (v_ext > acc_q);
      end
      msr_pkg::MODE_MAXABS: begin
        cand   = mag_ext;
        better = (mag_ext > acc_q);
      end
      msr_pkg::MODE_MINABS: begin
        cand   = mag_ext;
        better = (mag_ext < acc_q);
      end
      default: begin
        cand   = sat_sum;
        better = 1'b1;
      end
    endcase
  end

  // Run state next values
  always_comb begin
    acc_d      = acc_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    best_d     = best_q;
    best_vld_d = best_vld_q;
    priority if (cfg_we_i && (cfg_index_i == msr_pkg::REG_REDUCE_MODE)) begin
      acc_d      = msr_pkg::start_value(msr_pkg::eff_mode(cfg_wdata_i[msr_pkg::MODE_W-1:0]));
      pos_d      = '0;
      cnt_d      = '0;
      best_vld_d = 1'b0;
    end else if (cmd_i.load_out) begin
      acc_d      = msr_pkg::start_value(mode);
      pos_d      = '0;
      cnt_d      = '0;
      best_vld_d = 1'b0;
    end else if (cmd_i.update) begin
      if (incl_q) begin
        if (better) begin
          acc_d = cand;
          if (msr_pkg::is_minmax(mode)) begin
            best_d     = pos_q;
            best_vld_d = 1'b1;
          end
        end
        if (cnt_q != CW'(MAX_SAMPLES)) cnt_d = cnt_q + 1'b1;
      end
      pos_d = (pos_q == PW'(MAX_SAMPLES - 1)) ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= msr_pkg::start_value(msr_pkg::MODE_SUM);
      pos_q      <= '0;
      cnt_q      <= '0;
      best_q     <= '0;
      best_vld_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      pos_q      <= pos_d;
      cnt_q      <= cnt_d;
      best_q     <= best_d;
      best_vld_q <= best_vld_d;
    end
  end

  // Average divide
  assign need_div = msr_pkg::is_avg(mode) && (cnt_q != '0);

  msr_div #(
    .DVS_W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q <= need_div ? div_quot : acc_q;
      win_q <= (msr_pkg::is_minmax(mode) && best_vld_q) ? msr_pkg::OUT_POS_W'(best_q) : '1;
      tot_q <= msr_pkg::OUT_CNT_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{msr_pkg::OUT_PAD_W{1'b0}}, tot_q, win_q, res_q};

  // Status to controller
  always_comb begin
    status_o.last     = last_q;
    status_o.need_div = need_div;
    status_o.div_done = div_done;
    status_o.out_full = out_valid_q && !out_ready_i;
  end

endmodule

/* design/masked_stream_reduction.sv */
// Top level of the masked stream reduction block: controller plus datapath.
`timescale 1ns / 1ps

// Reduces a run of signed Q16.16 samples, filtered by group mask, to one saturated
// Q48.16 result with the winning sample position (min/max modes) and the included
// count, emitted when the sample marked tlast has been processed. Each sample is
// captured, with its square registered in the 32x32 multiplier, and then used to
// update the accumulator. After the last sample of a run the controller closes the
// run, in the average modes with a nonzero count runs the one-bit-per-cycle
// restoring divider, and then loads the output register. The output register lets
// the next run's samples flow in while a result waits to be taken.
// Writing reduce_mode restarts the run in progress.
module masked_stream_reduction #(
  parameter int unsigned MAX_SAMPLES = msr_pkg::DEFAULT_MAX_SAMPLES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [msr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [msr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Sample stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] sample_value, [63:32] member_bits
  input  logic [msr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tlast,
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [63:0] reduced_value, [80:64] winner_position, [97:81] included_total, rest zero
  output logic [msr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  msr_pkg::cmd_t    cmd;
  msr_pkg::status_t status;

  msr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  msr_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* design/msr_checker.sv */
// Port-level checker for the masked stream reduction block and its bind statement.
`timescale 1ns / 1ps

module msr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [msr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input logic [msr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [msr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [msr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // One sample at a time: ready drops after each input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted in back-to-back cycles");

  // A sample that does not close a run frees the input again after its update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |-> ##2 s_axis_tready)
    else $error("input not ready again after a mid-run sample");

  // A new result appears only out of the emit step, when input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an emit step");

endmodule

bind masked_stream_reduction msr_checker u_msr_checker (.*);
